// ===== hdl/vpco_pkg.sv =====
// ----------------------------------------------------------------------------
// vpco_pkg: shared types and constants for the victim page cache order block
// Action and status codes, controller states, and command/status structs.
// ----------------------------------------------------------------------------
package vpco_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VIRTUAL_PAGES_DEF = 4096;
	localparam int PAGE_W = 12;
	localparam int ACT_W = 3;
	localparam int STAT_W = 3;
	localparam int COUNT_W = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_EVICT  = 3'd2,
		ACT_PEEK   = 3'd3,
		ACT_QUERY  = 3'd4
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_ABSENT = 3'd3,
		ST_DUP    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_EXEC,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_step;  // write one map entry to zero during sweep
		logic load;        // capture input beat
		logic lookup;      // read map at captured page
		logic exec;        // perform action, update links and map
	} vpco_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
	} vpco_sts_t;

endpackage

// ===== hdl/victim_page_cache_order.sv =====
// ----------------------------------------------------------------------------
// victim_page_cache_order: page cache with insertion-order eviction
// Holds up to CAPACITY pages in a linked order with a page-indexed map.
// ----------------------------------------------------------------------------
// After reset the block sweeps the page map, one entry per cycle, and clears
// every entry before it takes the first beat. Each beat then passes through
// capture, registered map read, execute and result beat; the block holds the
// result until m_tready is high, since the next input beat is taken only after
// the result is taken.
module victim_page_cache_order #(
	parameter int CAPACITY = vpco_pkg::CAPACITY_DEF,
	parameter int VIRTUAL_PAGES = vpco_pkg::VIRTUAL_PAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [2:0] action, [14:3] page_number
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // [2:0] status, [14:3] result_page,
	                              // [15] present, [20:16] used_count
);

	vpco_pkg::vpco_cmd_t cmd;
	vpco_pkg::vpco_sts_t sts;
	logic [vpco_pkg::STAT_W-1:0]  status;
	logic [vpco_pkg::PAGE_W-1:0]  result_page;
	logic                         present;
	logic [vpco_pkg::COUNT_W-1:0] used_count;

	vpco_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd(cmd), .sts(sts)
	);

	vpco_datapath #(.CAPACITY(CAPACITY), .VIRTUAL_PAGES(VIRTUAL_PAGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_action(s_tdata[2:0]), .in_page(s_tdata[14:3]),
		.out_status(status), .out_page(result_page),
		.out_present(present), .out_count(used_count)
	);

	assign m_tdata = {3'b000, used_count, present, result_page, status};

endmodule

// ===== hdl/vpco_datapath.sv =====
// ----------------------------------------------------------------------------
// vpco_datapath: slot storage, link lists, page map memory and result register
// Executes one action in the exec cycle using the map entry read in lookup.
// ----------------------------------------------------------------------------
module vpco_datapath #(
	parameter int CAPACITY = vpco_pkg::CAPACITY_DEF,
	parameter int VIRTUAL_PAGES = vpco_pkg::VIRTUAL_PAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vpco_pkg::vpco_cmd_t          cmd,
	output vpco_pkg::vpco_sts_t          sts,
	input  logic [vpco_pkg::ACT_W-1:0]   in_action,
	input  logic [vpco_pkg::PAGE_W-1:0]  in_page,
	output logic [vpco_pkg::STAT_W-1:0]  out_status,
	output logic [vpco_pkg::PAGE_W-1:0]  out_page,
	output logic                         out_present,
	output logic [vpco_pkg::COUNT_W-1:0] out_count
);

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int MAP_W = SLOT_W + 1;
	localparam int VP_W = (VIRTUAL_PAGES > 1) ? $clog2(VIRTUAL_PAGES) : 1;
	localparam int HELD_W = $clog2(CAPACITY + 1);
	localparam int PW = vpco_pkg::PAGE_W;
	// one spare bit so VIRTUAL_PAGES itself fits in the range compare
	localparam int PWX = ((VP_W > PW) ? VP_W : PW) + 1;

	logic [PW-1:0]     slot_page_q  [CAPACITY];
	logic [SLOT_W-1:0] older_q      [CAPACITY];
	logic [SLOT_W-1:0] newer_q      [CAPACITY];
	logic [CAPACITY-1:0] free_q;
	logic [SLOT_W-1:0] oldest_q, newest_q;
	logic [HELD_W-1:0] held_q;

	logic [MAP_W-1:0]  map_mem [VIRTUAL_PAGES];
	logic [MAP_W-1:0]  map_rd_q;
	logic [VP_W:0]     clr_q;

	logic [vpco_pkg::ACT_W-1:0] act_q;
	logic [PW-1:0]              page_q;

	// page within map range
	logic [PWX-1:0] page_x;
	logic           in_range;
	logic [VP_W-1:0] page_idx;
	assign page_x = PWX'(page_q);
	assign in_range = page_x < PWX'(VIRTUAL_PAGES);
	assign page_idx = page_x[VP_W-1:0];

	logic held_now;
	assign held_now = in_range && (map_rd_q != '0);

	assign sts.clear_done = clr_q[VP_W] || (clr_q == (VP_W+1)'(VIRTUAL_PAGES));

	// first free slot
	logic [SLOT_W-1:0] free_slot;
	always_comb begin
		free_slot = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) free_slot = SLOT_W'(i);
		end
	end

	// execute decisions
	logic              do_ins, do_unlink, map_wr;
	logic [SLOT_W-1:0] us;
	logic [VP_W-1:0]   map_wa;
	logic [MAP_W-1:0]  map_wd;
	logic [vpco_pkg::STAT_W-1:0] st;
	logic [PW-1:0]     rp;
	logic              pr;

	always_comb begin
		do_ins = 1'b0;
		do_unlink = 1'b0;
		us = '0;
		st = vpco_pkg::ST_OK;
		rp = page_q;
		pr = 1'b0;
		unique case (act_q)
			vpco_pkg::ACT_INSERT: begin
				if (held_now) begin
					st = vpco_pkg::ST_DUP;
					pr = 1'b1;
				end else if (!in_range) begin
					st = vpco_pkg::ST_ABSENT;
				end else if (held_q >= HELD_W'(CAPACITY)) begin
					st = vpco_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					pr = 1'b1;
				end
			end
			vpco_pkg::ACT_REMOVE: begin
				if (!held_now) st = vpco_pkg::ST_ABSENT;
				else begin
					do_unlink = 1'b1;
					us = map_rd_q[SLOT_W-1:0] - SLOT_W'(1);
				end
			end
			vpco_pkg::ACT_EVICT, vpco_pkg::ACT_PEEK: begin
				if (held_q == '0) begin
					st = vpco_pkg::ST_EMPTY;
					rp = '0;
				end else begin
					rp = slot_page_q[oldest_q];
					us = oldest_q;
					if (act_q == vpco_pkg::ACT_EVICT) do_unlink = 1'b1;
					else pr = 1'b1;
				end
			end
			vpco_pkg::ACT_QUERY: begin
				if (held_now) pr = 1'b1;
				else st = vpco_pkg::ST_ABSENT;
			end
			default: pr = held_now;
		endcase
	end

	// map write port: sweep, insert or unlink
	logic [PWX-1:0] us_page_x;
	assign us_page_x = PWX'(slot_page_q[us]);
	always_comb begin
		map_wr = 1'b0;
		map_wa = '0;
		map_wd = '0;
		if (cmd.clear_step) begin
			map_wr = 1'b1;
			map_wa = clr_q[VP_W-1:0];
		end else if (cmd.exec && do_ins) begin
			map_wr = 1'b1;
			map_wa = page_idx;
			map_wd = MAP_W'(free_slot) + MAP_W'(1);
		end else if (cmd.exec && do_unlink && us_page_x < PWX'(VIRTUAL_PAGES)) begin
			map_wr = 1'b1;
			map_wa = us_page_x[VP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (map_wr) map_mem[map_wa] <= map_wd;
		if (cmd.lookup) map_rd_q <= in_range ? map_mem[page_idx] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + (VP_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			page_q <= in_page;
		end
		if (cmd.exec && do_ins) begin
			slot_page_q[free_slot] <= page_q;
			if (held_q != '0) begin
				newer_q[newest_q] <= free_slot;
				older_q[free_slot] <= newest_q;
			end
		end
		if (cmd.exec && do_unlink && held_q > HELD_W'(1)
				&& us != oldest_q && us != newest_q) begin
			newer_q[older_q[us]] <= newer_q[us];
			older_q[newer_q[us]] <= older_q[us];
		end
		if (cmd.exec) begin
			out_status <= st;
			out_page <= rp;
			out_present <= pr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			oldest_q <= '0;
			newest_q <= '0;
			held_q <= '0;
			out_count <= '0;
		end else if (cmd.exec) begin
			if (do_ins) begin
				free_q[free_slot] <= 1'b0;
				if (held_q == '0) oldest_q <= free_slot;
				newest_q <= free_slot;
				held_q <= held_q + HELD_W'(1);
				out_count <= vpco_pkg::COUNT_W'(held_q + HELD_W'(1));
			end else if (do_unlink) begin
				if (held_q <= HELD_W'(1)) begin
					oldest_q <= '0;
					newest_q <= '0;
				end else if (us == oldest_q) begin
					oldest_q <= newer_q[us];
				end else if (us == newest_q) begin
					newest_q <= older_q[us];
				end
				free_q[us] <= 1'b1;
				held_q <= held_q - HELD_W'(1);
				out_count <= vpco_pkg::COUNT_W'(held_q - HELD_W'(1));
			end else begin
				out_count <= vpco_pkg::COUNT_W'(held_q);
			end
		end
	end

	// held count always matches occupied slots
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(~free_q) == int'(held_q))
		else $error("held count disagrees with free mask");

	assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(CAPACITY))
		else $error("held count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && do_ins |=> !free_q[$past(free_slot)])
		else $error("inserted slot still free");

endmodule

// ===== hdl/vpco_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpco_ctrl: sequencing controller
// Map clearing sweep after reset, then load / lookup / exec / output per beat.
// ----------------------------------------------------------------------------
module vpco_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output vpco_pkg::vpco_cmd_t cmd,
	input  vpco_pkg::vpco_sts_t sts
);

	vpco_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= vpco_pkg::S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			vpco_pkg::S_CLEAR: begin
				if (sts.clear_done) state_d = vpco_pkg::S_IDLE;
				else cmd.clear_step = 1'b1;
			end
			vpco_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = vpco_pkg::S_LOOKUP;
				end
			end
			vpco_pkg::S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d = vpco_pkg::S_EXEC;
			end
			vpco_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = vpco_pkg::S_OUT;
			end
			vpco_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = vpco_pkg::S_IDLE;
			end
			default: state_d = vpco_pkg::S_CLEAR;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.lookup)
		else $error("lookup did not follow load");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |=> cmd.exec ##1 out_valid)
		else $error("exec sequence broken");

endmodule
